// ===== design/hida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hida_pkg: shared types and constants of the ID allocator
// Field widths, status codes, the control/status structs between the
// controller and the datapath, and the release ID reduction table.
// ----------------------------------------------------------------------------
package hida_pkg;

   localparam int ID_FIELD_WIDTH   = 8;
   localparam int NOW_WIDTH        = 48;
   localparam int HOLDOFF_WIDTH    = 32;
   localparam int REQ_DATA_WIDTH   = 56;
   localparam int RSP_DATA_WIDTH   = 8;
   localparam int STATUS_WIDTH     = 2;
   localparam int ID_TABLE_DEPTH   = 256;

   localparam int ID_COUNT_DEFAULT  = 256;
   localparam int TIME_BITS_DEFAULT = 48;

   localparam logic [HOLDOFF_WIDTH-1:0] HOLDOFF_RESET = 32'd1000000;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_HOLDOFF = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;       // capture the accepted request beat
      logic do_release;  // push the ID into the ring and stamp its time
      logic do_full;     // release refused, ring full
      logic do_fresh;    // hand out a never-used ID
      logic do_empty;    // allocate refused, nothing free
      logic ring_rd;     // read the oldest ring entry
      logic time_rd;     // read the release time of that entry
      logic check;       // compare elapsed time against the holdoff
      logic load_out;    // move the result into the output register
   } hida_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_release;
      logic ring_full;
      logic ring_empty;
      logic fresh_zero;
      logic out_free;
   } hida_status_type;

   typedef logic [ID_FIELD_WIDTH-1:0] id_table_type [ID_TABLE_DEPTH];

   // Builds the table of each 8-bit ID reduced modulo the ID count.
   function automatic id_table_type build_id_table(input int count);
      id_table_type t;
      int r;
      r = 0;
      for (int i = 0; i < ID_TABLE_DEPTH; i++) begin
         t[i] = ID_FIELD_WIDTH'(r);
         r = (r + 1 >= count) ? 0 : r + 1;
      end
      return t;
   endfunction

endpackage

// ===== design/hida_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hida_ctrl: sequencing state machine of the ID allocator
// Accepts one request, steers the datapath through the release, fresh
// allocate or ring allocate sequence, and hands the result to the output.
// ----------------------------------------------------------------------------
module hida_ctrl
   import hida_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  hida_status_type status,
   output hida_cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_TIME  = 6'b000100,
      S_CHECK = 6'b001000,
      S_DONE  = 6'b010000,
      S_RING  = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (status.is_release) begin
               if (status.ring_full) begin
                  cmd.do_full = 1'b1;
               end else begin
                  cmd.do_release = 1'b1;
               end
            end else if (!status.fresh_zero) begin
               cmd.do_fresh = 1'b1;
            end else if (status.ring_empty) begin
               cmd.do_empty = 1'b1;
            end else begin
               cmd.ring_rd = 1'b1;
               state_in    = S_RING;
            end
         end
         S_RING: begin
            // Ring entry is now registered; fetch that ID's release time.
            cmd.time_rd = 1'b1;
            state_in    = S_TIME;
         end
         S_TIME: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== design/hida_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hida_dpath: datapath of the ID allocator
// Holds the free ring, the release time store, the ring pointers, the
// fresh ID counter, the holdoff register and the output register.
// ----------------------------------------------------------------------------
module hida_dpath
   import hida_pkg::*;
#(
   parameter int ID_COUNT  = ID_COUNT_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  hida_cmd_type                cmd,
   output hida_status_type             status,
   input  logic [REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [STATUS_WIDTH-1:0]     rsp_tuser,
   input  logic                        csr_tvalid,
   output logic                        csr_tready,
   input  logic [HOLDOFF_WIDTH-1:0]    csr_tdata
);

   localparam int IDW = $clog2(ID_COUNT);
   localparam int TSW = (TIME_BITS < NOW_WIDTH) ? TIME_BITS : NOW_WIDTH;
   localparam int CW  = (TIME_BITS > HOLDOFF_WIDTH) ? TIME_BITS : HOLDOFF_WIDTH;
   localparam logic [IDW-1:0] LAST_ID = IDW'(ID_COUNT - 1);
   localparam id_table_type ID_MOD_TABLE = build_id_table(ID_COUNT);

   // Stores are read only at entries written earlier, so no clearing.
   logic [IDW-1:0] ring_mem [ID_COUNT];
   logic [TSW-1:0] time_mem [ID_COUNT];

   logic                     is_release_ff;
   logic [IDW-1:0]           rid_ff;
   logic [TSW-1:0]           now_ff;
   logic [IDW-1:0]           ring_rd_ff;
   logic [TSW-1:0]           time_rd_ff;
   logic [IDW-1:0]           head_ff, head_in;
   logic [IDW-1:0]           tail_ff, tail_in;
   logic [IDW-1:0]           count_ff, count_in;
   logic [IDW-1:0]           fresh_ff, fresh_in;
   logic [HOLDOFF_WIDTH-1:0] holdoff_ff;
   logic [IDW-1:0]           gid_ff, gid_in;
   status_type               st_ff, st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDW-1:0]           rsp_gid_ff;
   status_type               rsp_st_ff;
   logic [TIME_BITS-1:0]     elapsed;
   logic                     holdoff_wait;

   // Request capture and the holdoff register.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         is_release_ff <= req_tuser;
         rid_ff        <= IDW'(ID_MOD_TABLE[req_tdata[ID_FIELD_WIDTH-1:0]]);
         now_ff        <= TSW'(req_tdata[ID_FIELD_WIDTH +: NOW_WIDTH]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= HOLDOFF_RESET;
      end else if (csr_tvalid) begin
         holdoff_ff <= csr_tdata;
      end
   end

   assign csr_tready = 1'b1;

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (cmd.do_release) begin
         ring_mem[head_ff] <= rid_ff;
      end
      if (cmd.ring_rd) begin
         ring_rd_ff <= ring_mem[tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_release) begin
         time_mem[rid_ff] <= now_ff;
      end
      if (cmd.time_rd) begin
         time_rd_ff <= time_mem[ring_rd_ff];
      end
   end

   // Modular age of the oldest freed ID against the holdoff.
   assign elapsed      = TIME_BITS'(now_ff) - TIME_BITS'(time_rd_ff);
   assign holdoff_wait = CW'(elapsed) < CW'(holdoff_ff);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      gid_in   = gid_ff;
      st_in    = st_ff;
      if (cmd.do_release) begin
         head_in  = (head_ff == LAST_ID) ? '0 : head_ff + 1'b1;
         count_in = count_ff + 1'b1;
         gid_in   = '0;
         st_in    = STATUS_OK;
      end
      if (cmd.do_full) begin
         gid_in = '0;
         st_in  = STATUS_FULL;
      end
      if (cmd.do_fresh) begin
         gid_in   = fresh_ff;
         fresh_in = fresh_ff - 1'b1;
         st_in    = STATUS_OK;
      end
      if (cmd.do_empty) begin
         gid_in = LAST_ID;
         st_in  = STATUS_NO_FREE;
      end
      if (cmd.check) begin
         if (holdoff_wait) begin
            gid_in = LAST_ID;
            st_in  = STATUS_HOLDOFF;
         end else begin
            gid_in   = ring_rd_ff;
            st_in    = STATUS_OK;
            tail_in  = (tail_ff == LAST_ID) ? '0 : tail_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= LAST_ID;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      gid_ff <= gid_in;
      st_ff  <= st_in;
   end

   // Output register: frees the core while a result waits downstream.
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_gid_ff <= gid_ff;
         rsp_st_ff  <= st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_gid_ff);
   assign rsp_tuser  = rsp_st_ff;

   assign status.is_release = is_release_ff;
   assign status.ring_full  = (count_ff == LAST_ID);
   assign status.ring_empty = (count_ff == '0);
   assign status.fresh_zero = (fresh_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_ID)
      else $error("free ring occupancy exceeds its capacity");

   a_reuse_pops: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && !holdoff_wait) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("granted ring ID did not leave the ring");

   a_fresh_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.do_fresh |=> $stable(fresh_ff))
      else $error("fresh ID counter moved without a fresh grant");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result beat appeared without a load");
`endif

endmodule

// ===== design/holdoff_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holdoff_id_allocator: small ID allocator with a reuse holdoff
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Each request beat either allocates an ID (tuser low) or releases one
// (tuser high) and produces exactly one response beat carrying the ID and a
// status code. Allocation first hands out never-used IDs from ID_COUNT-1
// down to 1; after that it takes the oldest released ID from a FIFO ring,
// but only once at least reuse_holdoff time units have passed since that ID
// was released, judged by a modular difference of the request timestamps.
// A failed allocate returns ID_COUNT-1 with status "no free ID" or "holdoff
// pending" and leaves the ring untouched. A release stores the ID (reduced
// modulo ID_COUNT) and its timestamp; it fails with "ring full" once the
// ring holds ID_COUNT-1 entries. The block works on one request at a time.
// A release, a fresh allocate or a "no free ID" refusal goes from the
// execute state straight to the done state; an allocate from the ring
// first passes through two dependent registered memory reads (ring entry,
// then that ID's release time), a wait state and the elapsed-time compare.
// In the done state the result moves into the output register once that is
// free, and the next request is accepted in the cycle after. A new request
// is accepted while the previous response still waits in the output
// register; the block stalls only when a second result is ready before
// that one leaves. The holdoff register is written through the csr
// channel, which is always ready, and must be written only while no
// request is in flight. No clearing pass is needed after reset: the stores
// are read only at entries that a release has written.
// ----------------------------------------------------------------------------
module holdoff_id_allocator
   import hida_pkg::*;
#(
   parameter int ID_COUNT  = ID_COUNT_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]   req_tdata,  // [7:0] release_id, [55:8] now
   input  logic                        req_tuser,  // [0] cmd: 0 allocate, 1 release
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]   rsp_tdata,  // [7:0] granted_id
   output logic [STATUS_WIDTH-1:0]     rsp_tuser,  // [1:0] status
   // Holdoff register write channel.
   input  logic                        csr_tvalid,
   output logic                        csr_tready,
   input  logic [HOLDOFF_WIDTH-1:0]    csr_tdata   // [31:0] reuse_holdoff
);

   hida_cmd_type    cmd;
   hida_status_type status;

   hida_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hida_dpath #(
      .ID_COUNT  (ID_COUNT),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

endmodule

// ===== test/tb_holdoff_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_holdoff_id_allocator: self-checking testbench of the ID allocator
// Sends allocate and release beats with random gaps and stalls. A local
// model of the allocator predicts each response, and a checker compares
// every response beat with the oldest prediction. The holdoff register is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_holdoff_id_allocator;
   import hida_pkg::*;

   localparam int ID_COUNT = ID_COUNT_DEFAULT;

   // Command codes carried in req_tuser.
   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;
   // Quiet cycles before a register write and at the very end.
   localparam int SETTLE_CYCLES = 10;
   // Length of the long receiver hold-off, in cycles.
   localparam int PARK_CYCLES   = 400;

   typedef struct packed {
      logic [ID_FIELD_WIDTH-1:0] id;
      status_type                status;
   } grant_beat_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [STATUS_WIDTH-1:0]   rsp_tuser;
   logic                      csr_tvalid;
   logic                      csr_tready;
   logic [HOLDOFF_WIDTH-1:0]  csr_tdata;

   holdoff_id_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   // Model of the allocator state, kept in step with every accepted request.
   logic [HOLDOFF_WIDTH-1:0] model_holdoff;
   int                       fresh_left;
   int                       ring_wr;
   int                       ring_rd;
   int                       ring_ids [ID_COUNT];
   logic [NOW_WIDTH-1:0]     stamp_of [ID_COUNT];

   // Responses predicted but not yet seen, oldest first.
   grant_beat_type pending_grants [$];
   // IDs currently handed out, so that most releases return a real ID.
   int             held_ids [$];
   // Running timestamp of the traffic.
   logic [NOW_WIDTH-1:0] stamp_now;

   int fail_count;
   bit steady_phase;
   bit park_request;

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   function automatic int ring_step(input int p);
      return (p + 1 >= ID_COUNT) ? 0 : p + 1;
   endfunction

   function automatic int ring_count();
      return (ring_wr + ID_COUNT - ring_rd) % ID_COUNT;
   endfunction

   // Applies one request to the model and returns the response it causes.
   function automatic grant_beat_type predict_grant(input logic cmd,
                                                    input logic [ID_FIELD_WIDTH-1:0] id,
                                                    input logic [NOW_WIDTH-1:0] stamp);
      grant_beat_type       r;
      int                   slot;
      int                   cand;
      logic [NOW_WIDTH-1:0] elapsed;
      r.id = '0;
      r.status = STATUS_OK;
      if (cmd == CMD_RELEASE) begin
         if (ring_count() >= ID_COUNT - 1) begin
            r.status = STATUS_FULL;
         end else begin
            slot = int'(id) % ID_COUNT;
            ring_ids[ring_wr] = slot;
            ring_wr = ring_step(ring_wr);
            stamp_of[slot] = stamp;
         end
      end else if (fresh_left > 0) begin
         r.id = ID_FIELD_WIDTH'(fresh_left);
         fresh_left--;
      end else if (ring_wr == ring_rd) begin
         r.id = ID_FIELD_WIDTH'(ID_COUNT - 1);
         r.status = STATUS_NO_FREE;
      end else begin
         // The elapsed time is a modular difference, so a wrap of the
         // timestamp between release and reuse is harmless.
         cand = ring_ids[ring_rd];
         elapsed = stamp - stamp_of[cand];
         if (elapsed < NOW_WIDTH'(model_holdoff)) begin
            r.id = ID_FIELD_WIDTH'(ID_COUNT - 1);
            r.status = STATUS_HOLDOFF;
         end else begin
            r.id = ID_FIELD_WIDTH'(cand);
            ring_rd = ring_step(ring_rd);
         end
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic int draw_idle();
      if (steady_phase)
         return 0;
      return $urandom_range(0, 12);
   endfunction

   // Moves the running timestamp forward. Most steps are a fraction of the
   // holdoff so that pending and expired holdoffs both occur; a few are huge
   // jumps that wrap, and a few beats carry an arbitrary timestamp.
   function automatic logic [NOW_WIDTH-1:0] advance_stamp();
      logic [NOW_WIDTH-1:0] step;
      int unsigned          span;
      span = (model_holdoff >> 4) + 3;
      case ($urandom_range(0, 19))
         0: step = '0;
         1: step = NOW_WIDTH'({$urandom, $urandom});
         2: step = NOW_WIDTH'(model_holdoff);
         default: step = NOW_WIDTH'($urandom_range(0, span));
      endcase
      stamp_now = stamp_now + step;
      if ($urandom_range(0, 39) == 0)
         return NOW_WIDTH'({$urandom, $urandom});
      return stamp_now;
   endfunction

   // Sends one request beat and records the response it must cause. The
   // valid stays high after the beat so that back-to-back beats never
   // lower and raise it in the same step.
   task automatic send_request(input logic cmd,
                               input logic [ID_FIELD_WIDTH-1:0] id,
                               input logic [NOW_WIDTH-1:0] stamp);
      int             gap;
      grant_beat_type g;
      gap = draw_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {stamp, id};
      do @(posedge clock); while (!req_tready);
      g = predict_grant(cmd, id, stamp);
      pending_grants.push_back(g);
      if (cmd == CMD_ALLOCATE && g.status == STATUS_OK)
         held_ids.push_back(int'(g.id));
   endtask

   // Returns a held ID most of the time, otherwise any 8-bit value.
   function automatic logic [ID_FIELD_WIDTH-1:0] pick_release_id();
      int k;
      int id;
      if (held_ids.size() > 0 && $urandom_range(0, 9) != 0) begin
         k = $urandom_range(0, held_ids.size() - 1);
         id = held_ids[k];
         held_ids.delete(k);
         return ID_FIELD_WIDTH'(id);
      end
      return ID_FIELD_WIDTH'($urandom);
   endfunction

   // Stops offering beats and waits until every response has arrived and
   // the block has had time to settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_holdoff(input logic [HOLDOFF_WIDTH-1:0] value);
      wait_idle();
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      do @(posedge clock); while (!csr_tready);
      model_holdoff = value;
      csr_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset holdoff, fresh IDs still available: both commands, ID zero, the
   // top ID, an ID never handed out, and the timestamp extremes.
   task automatic test_directed();
      send_request(CMD_ALLOCATE, 8'h00, 48'h0);
      send_request(CMD_ALLOCATE, 8'hFF, 48'hFFFF_FFFF_FFFF);
      send_request(CMD_RELEASE, 8'h00, 48'h0);
      send_request(CMD_RELEASE, 8'hFF, 48'hFFFF_FFFF_FFFF);
      send_request(CMD_RELEASE, 8'hFE, 48'h0000_0000_0001);
      send_request(CMD_RELEASE, 8'hA5, 48'h5A5A_5A5A_5A5A);
      send_request(CMD_RELEASE, 8'h5A, 48'hA5A5_A5A5_A5A5);
      send_request(CMD_ALLOCATE, 8'h5A, 48'h8000_0000_0000);
      held_ids.delete();
   endtask

   // Hands out every never-used ID, then drains the ring with no holdoff,
   // then asks again with nothing left.
   task automatic test_fresh_exhaustion();
      write_holdoff('0);
      while (fresh_left > 0)
         send_request(CMD_ALLOCATE, ID_FIELD_WIDTH'($urandom), advance_stamp());
      while (ring_wr != ring_rd)
         send_request(CMD_ALLOCATE, ID_FIELD_WIDTH'($urandom), advance_stamp());
      send_request(CMD_ALLOCATE, 8'h00, stamp_now);
      send_request(CMD_ALLOCATE, 8'hFF, stamp_now);
   endtask

   // Exact holdoff boundary, the boundary across a timestamp wrap, and the
   // largest holdoff.
   task automatic test_holdoff_boundary();
      logic [NOW_WIDTH-1:0] t;
      write_holdoff(32'd1000);
      t = stamp_now + 48'd5000;
      send_request(CMD_RELEASE, 8'd7, t);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'd999);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'd1000);
      t = 48'hFFFF_FFFF_FFF0;
      send_request(CMD_RELEASE, 8'd9, t);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'd999);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'd1000);
      stamp_now = t + 48'd1000;
      write_holdoff('1);
      t = stamp_now;
      send_request(CMD_RELEASE, 8'd3, t);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'hFFFF_FFFE);
      send_request(CMD_ALLOCATE, 8'd0, t + 48'hFFFF_FFFF);
      stamp_now = t + 48'hFFFF_FFFF;
      send_request(CMD_ALLOCATE, 8'd0, stamp_now);
      held_ids.delete();
   endtask

   // Fills the ring to capacity, refuses further releases, then drains it
   // once the holdoff has run out for every entry.
   task automatic test_ring_full();
      write_holdoff(HOLDOFF_RESET);
      while (ring_count() < ID_COUNT - 1)
         send_request(CMD_RELEASE, ID_FIELD_WIDTH'($urandom), stamp_now);
      repeat (3)
         send_request(CMD_RELEASE, ID_FIELD_WIDTH'($urandom), stamp_now);
      send_request(CMD_ALLOCATE, 8'd0, stamp_now + NOW_WIDTH'(HOLDOFF_RESET - 1));
      stamp_now = stamp_now + NOW_WIDTH'(HOLDOFF_RESET);
      while (ring_wr != ring_rd)
         send_request(CMD_ALLOCATE, ID_FIELD_WIDTH'($urandom), stamp_now);
   endtask

   // The receiver parks for a long stretch while the sender keeps offering
   // beats back to back, so the request side must stall.
   task automatic test_backpressure();
      steady_phase = 1'b1;
      park_request = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 1) == 1)
            send_request(CMD_RELEASE, pick_release_id(), advance_stamp());
         else
            send_request(CMD_ALLOCATE, ID_FIELD_WIDTH'($urandom), advance_stamp());
      end
      steady_phase = 1'b0;
   endtask

   // Mixed traffic in phases, each with its own holdoff and release bias.
   task automatic test_random_traffic(input int phases, input int per_phase);
      int                        bias;
      logic                      cmd;
      logic [HOLDOFF_WIDTH-1:0]  hold;
      logic [ID_FIELD_WIDTH-1:0] id;
      for (int p = 0; p < phases; p++) begin
         case (p % 6)
            0: hold = HOLDOFF_RESET;
            1: hold = '0;
            2: hold = 32'd17;
            3: hold = '1;
            4: hold = $urandom_range(1, 5000);
            default: hold = $urandom;
         endcase
         write_holdoff(hold);
         bias = $urandom_range(20, 80);
         steady_phase = (p % 3 == 2);
         repeat (per_phase) begin
            cmd = ($urandom_range(1, 100) <= bias) ? CMD_RELEASE : CMD_ALLOCATE;
            id = (cmd == CMD_RELEASE) ? pick_release_id() : ID_FIELD_WIDTH'($urandom);
            send_request(cmd, id, advance_stamp());
         end
      end
      steady_phase = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Receiver: stalls a random number of cycles before each beat, or for a
   // long stretch when a test asks for it.
   initial begin : receiver
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (park_request) begin
            park_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (PARK_CYCLES) @(posedge clock);
         end else begin
            stall = draw_idle();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Checker: every response beat must match the oldest prediction.
   always @(posedge clock) begin
      grant_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response beat: id %0d status %0d", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tdata !== want.id || rsp_tuser !== want.status) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response mismatch: expected id %0d status %0d, got id %0d status %0d",
                           want.id, want.status, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // Watchdog: ends the run if no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_tvalid && csr_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** holdoff_id_allocator: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      csr_tvalid   = 1'b0;
      csr_tdata    = '0;
      fail_count   = 0;
      steady_phase = 1'b0;
      park_request = 1'b0;
      stamp_now    = '0;
      // Model state after reset.
      model_holdoff = HOLDOFF_RESET;
      fresh_left    = ID_COUNT - 1;
      ring_wr       = 0;
      ring_rd       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fresh_exhaustion();
      test_holdoff_boundary();
      test_ring_full();
      test_backpressure();
      test_random_traffic(8, 100);

      wait_idle();
      if (fail_count == 0 && pending_grants.size() == 0)
         $display("** holdoff_id_allocator: PASSED **");
      else
         $display("** holdoff_id_allocator: FAILED **");
      $finish;
   end

endmodule
